// ===== sv/mrpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the readout parser and filter.
// No dependencies.
package mrpf_pkg;

    localparam int NUM_ADC = 8;
    localparam int IDX_W   = $clog2(NUM_ADC);
    localparam int ADC_W   = 14;
    localparam int TIME_W  = 30;
    localparam int WCNT_W  = 12;
    localparam int MOD_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [IDX_W-1:0] ADC_LAST = IDX_W'(NUM_ADC - 1);

    localparam logic [31:0]       ID_MASK_RST    = 32'hff00_0000;
    localparam logic [WCNT_W-1:0] WORD_COUNT_RST = 12'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_IDENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_IDENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_IDENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIRE_THR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_THR     = 3'd6;

    typedef logic [ADC_W-1:0] t_adc;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_FOOT = 2'd2
    } t_phase;

    typedef struct packed {
        logic              hdr;
        logic              dat;
        logic              ftr;
        logic              eob;
        logic [TIME_W-1:0] word;
    } t_item;

endpackage

// ===== sv/mrpf_front.sv =====
`timescale 1ns / 1ps
// Front classifier: tags each readout word as header, data or footer.
// Depends on mrpf_pkg.
module mrpf_front
    import mrpf_pkg::*;
(
    input  logic [31:0]       i_word,
    input  logic              i_eob,
    input  logic [31:0]       i_id_mask,
    input  logic [31:0]       i_header_ident,
    input  logic [31:0]       i_data_ident,
    input  logic [31:0]       i_footer_ident,
    input  logic [WCNT_W-1:0] i_word_count,
    output t_item             o_item
);

    logic [31:0] w_tag;

    assign w_tag = i_word & i_id_mask;

    always_comb begin
        o_item.hdr  = (w_tag == i_header_ident) && (i_word[WCNT_W-1:0] == i_word_count);
        o_item.dat  = (w_tag == i_data_ident);
        o_item.ftr  = (w_tag == i_footer_ident);
        o_item.eob  = i_eob;
        o_item.word = i_word[TIME_W-1:0];
    end

endmodule

// ===== sv/mrpf_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified words between front and back.
// Depends on mrpf_pkg.
module mrpf_queue
    import mrpf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== sv/mrpf_back.sv =====
`timescale 1ns / 1ps
// Back end: frame parser, ADC hold registers, threshold filter and result register.
// Depends on mrpf_pkg.
module mrpf_back
    import mrpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    input  logic [ADC_W-1:0]  i_wire_thr,
    input  logic [ADC_W-1:0]  i_grid_thr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MOD_W-1:0]  o_module_res,
    output t_adc              o_adc [NUM_ADC],
    output logic [TIME_W-1:0] o_timestamp,
    output logic              o_valid_res
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [MOD_W-1:0]   r_module;
    logic [MOD_W-1:0]   n_module;
    t_adc               r_adc [NUM_ADC];
    logic               r_out_valid;
    logic [MOD_W-1:0]   r_out_module;
    t_adc               r_out_adc [NUM_ADC];
    logic [TIME_W-1:0]  r_out_time;
    logic               r_out_ok;
    logic               w_take;
    logic               w_adc_we;
    logic               w_emit;
    logic               w_ok;

    assign w_take  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = w_take;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_module = r_module;
        if (w_take) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (i_q_item.dat) begin
                        n_idx = r_idx + IDX_W'(1);
                        if (r_idx == ADC_LAST) begin
                            n_phase = PH_FOOT;
                        end
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FOOT: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    if (i_q_item.hdr) begin
                        n_module = i_q_item.word[23:16];
                        n_idx    = '0;
                        n_phase  = PH_DATA;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
            if (i_q_item.eob) begin
                n_phase  = PH_HUNT;
                n_idx    = '0;
                n_module = '0;
            end
        end
    end

    always_comb begin
        w_adc_we = 1'b0;
        w_emit   = 1'b0;
        unique case (r_phase)
            PH_DATA: w_adc_we = w_take && i_q_item.dat;
            PH_FOOT: w_emit   = w_take && i_q_item.ftr;
            default: begin
                w_adc_we = 1'b0;
                w_emit   = 1'b0;
            end
        endcase
    end

    assign w_ok = (r_adc[0] >= i_wire_thr) && (r_adc[4] >= i_grid_thr) &&
                  (r_adc[1] <  i_wire_thr) && (r_adc[5] <  i_grid_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_idx       <= '0;
            r_module    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_module <= n_module;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adc_we) begin
            r_adc[r_idx] <= i_q_item.word[ADC_W-1:0];
        end
        if (w_emit) begin
            r_out_module <= r_module;
            r_out_adc    <= r_adc;
            r_out_time   <= i_q_item.word;
            r_out_ok     <= w_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_module_res = r_out_module;
    assign o_adc        = r_out_adc;
    assign o_timestamp  = r_out_time;
    assign o_valid_res  = r_out_ok;

endmodule

// ===== sv/multigrid_readout_parser_filter.sv =====
`timescale 1ns / 1ps
// Top level of the readout parser and single-hit filter: configuration registers,
// front classifier, queue and back-end parser. Depends on mrpf_pkg and its submodules.
//
//   Channel   Handshake                    Payload
//   input     i_in_valid / o_in_ready      i_word, i_end_of_buffer
//   output    o_out_valid / i_out_ready    o_module_res, o_adc0..7, o_timestamp, o_valid_res
//   config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request is accepted per cycle while the two-entry queue has room.
// The parser takes one queued request per cycle unless a result waits on the output.
// An accepted footer request is written into the queue, and the parser then loads the result register from it.
// While a result waits, the queue takes requests until both its entries are full; then the input stalls.
// Reset is synchronous and active low; it resets the parser, the queue and the configuration registers.
module multigrid_readout_parser_filter
    import mrpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_word,
    input  logic                 i_end_of_buffer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MOD_W-1:0]     o_module_res,
    output logic [ADC_W-1:0]     o_adc0,
    output logic [ADC_W-1:0]     o_adc1,
    output logic [ADC_W-1:0]     o_adc2,
    output logic [ADC_W-1:0]     o_adc3,
    output logic [ADC_W-1:0]     o_adc4,
    output logic [ADC_W-1:0]     o_adc5,
    output logic [ADC_W-1:0]     o_adc6,
    output logic [ADC_W-1:0]     o_adc7,
    output logic [TIME_W-1:0]    o_timestamp,
    output logic                 o_valid_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0]       r_id_mask;
    logic [31:0]       r_header_ident;
    logic [31:0]       r_data_ident;
    logic [31:0]       r_footer_ident;
    logic [WCNT_W-1:0] r_word_count;
    logic [ADC_W-1:0]  r_wire_thr;
    logic [ADC_W-1:0]  r_grid_thr;

    t_item             w_front_item;
    t_item             w_q_item;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_push;
    logic              w_pop;
    t_adc              w_adc [NUM_ADC];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_mask      <= ID_MASK_RST;
            r_header_ident <= '0;
            r_data_ident   <= '0;
            r_footer_ident <= '0;
            r_word_count   <= WORD_COUNT_RST;
            r_wire_thr     <= '0;
            r_grid_thr     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ID_MASK:      r_id_mask      <= i_cfg_data;
                CFG_HEADER_IDENT: r_header_ident <= i_cfg_data;
                CFG_DATA_IDENT:   r_data_ident   <= i_cfg_data;
                CFG_FOOTER_IDENT: r_footer_ident <= i_cfg_data;
                CFG_WORD_COUNT:   r_word_count   <= i_cfg_data[WCNT_W-1:0];
                CFG_WIRE_THR:     r_wire_thr     <= i_cfg_data[ADC_W-1:0];
                CFG_GRID_THR:     r_grid_thr     <= i_cfg_data[ADC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    mrpf_front u_front (
        .i_word         (i_word),
        .i_eob          (i_end_of_buffer),
        .i_id_mask      (r_id_mask),
        .i_header_ident (r_header_ident),
        .i_data_ident   (r_data_ident),
        .i_footer_ident (r_footer_ident),
        .i_word_count   (r_word_count),
        .o_item         (w_front_item)
    );

    mrpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    mrpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_pop),
        .i_wire_thr   (r_wire_thr),
        .i_grid_thr   (r_grid_thr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_module_res (o_module_res),
        .o_adc        (w_adc),
        .o_timestamp  (o_timestamp),
        .o_valid_res  (o_valid_res)
    );

    assign o_adc0 = w_adc[0];
    assign o_adc1 = w_adc[1];
    assign o_adc2 = w_adc[2];
    assign o_adc3 = w_adc[3];
    assign o_adc4 = w_adc[4];
    assign o_adc5 = w_adc[5];
    assign o_adc6 = w_adc[6];
    assign o_adc7 = w_adc[7];

`ifndef SYNTHESIS
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_valid |-> o_in_ready)
        else $error("Input stalled while the queue is empty.");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("Parser took a word from an empty queue.");

    a_result_from_footer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop && w_q_item.ftr))
        else $error("Result raised without a footer taken from the queue.");
`endif

endmodule

// ===== verif/tb_multigrid_readout_parser_filter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the readout parser and single-hit filter.
// Drives readout frames, noise and register writes, and predicts every event.
// Depends on mrpf_pkg and multigrid_readout_parser_filter.
module tb_multigrid_readout_parser_filter;
    import mrpf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int FRAME_WORDS  = NUM_ADC + 2;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [MOD_W-1:0]         module_no;
        t_adc [NUM_ADC-1:0]       adc;
        logic [TIME_W-1:0]        stamp;
        logic                     hit_ok;
    } t_hit_event;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [31:0]          i_word          = '0;
    logic                 i_end_of_buffer = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [MOD_W-1:0]     o_module_res;
    logic [ADC_W-1:0]     o_adc0, o_adc1, o_adc2, o_adc3;
    logic [ADC_W-1:0]     o_adc4, o_adc5, o_adc6, o_adc7;
    logic [TIME_W-1:0]    o_timestamp;
    logic                 o_valid_res;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [31:0]          i_cfg_data      = '0;

    // Shadow copy of the registers and the parser state.
    logic [31:0]       sh_id_mask;
    logic [31:0]       sh_header_ident;
    logic [31:0]       sh_data_ident;
    logic [31:0]       sh_footer_ident;
    logic [WCNT_W-1:0] sh_word_count;
    t_adc              sh_wire_thr;
    t_adc              sh_grid_thr;
    t_phase            sh_phase;
    logic [IDX_W-1:0]  sh_slot;
    logic [MOD_W-1:0]  sh_module;
    t_adc              sh_adc [NUM_ADC];

    t_hit_event hit_events_due [$];
    int         mismatches  = 0;
    int         idle_cycles = 0;
    int         rx_hold     = 0;
    bit         throttle    = 1'b1;

    multigrid_readout_parser_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_word          (i_word),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_module_res    (o_module_res),
        .o_adc0          (o_adc0),
        .o_adc1          (o_adc1),
        .o_adc2          (o_adc2),
        .o_adc3          (o_adc3),
        .o_adc4          (o_adc4),
        .o_adc5          (o_adc5),
        .o_adc6          (o_adc6),
        .o_adc7          (o_adc7),
        .o_timestamp     (o_timestamp),
        .o_valid_res     (o_valid_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_shadow();
        sh_id_mask      = ID_MASK_RST;
        sh_header_ident = '0;
        sh_data_ident   = '0;
        sh_footer_ident = '0;
        sh_word_count   = WORD_COUNT_RST;
        sh_wire_thr     = '0;
        sh_grid_thr     = '0;
        sh_phase        = PH_HUNT;
        sh_slot         = '0;
        sh_module       = '0;
    endfunction

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
        case (idx)
            CFG_ID_MASK:      sh_id_mask      = data;
            CFG_HEADER_IDENT: sh_header_ident = data;
            CFG_DATA_IDENT:   sh_data_ident   = data;
            CFG_FOOTER_IDENT: sh_footer_ident = data;
            CFG_WORD_COUNT:   sh_word_count   = data[WCNT_W-1:0];
            CFG_WIRE_THR:     sh_wire_thr     = data[ADC_W-1:0];
            CFG_GRID_THR:     sh_grid_thr     = data[ADC_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the shadow parser by one word; returns 1 when a good footer ends a frame.
    function automatic logic step_parser(input logic [31:0] w, input logic eob,
                                         output t_hit_event ev);
        logic [31:0] tag;
        logic        fired;
        tag   = w & sh_id_mask;
        fired = 1'b0;
        ev    = '0;
        case (sh_phase)
            PH_DATA: begin
                if (tag != sh_data_ident) begin
                    sh_phase = PH_HUNT;
                end else begin
                    sh_adc[sh_slot] = w[ADC_W-1:0];
                    sh_slot = sh_slot + IDX_W'(1);
                    if (sh_slot == '0) begin
                        sh_phase = PH_FOOT;
                    end
                end
            end
            PH_FOOT: begin
                if (tag == sh_footer_ident) begin
                    ev.module_no = sh_module;
                    for (int i = 0; i < NUM_ADC; i++) begin
                        ev.adc[i] = sh_adc[i];
                    end
                    ev.stamp  = w[TIME_W-1:0];
                    ev.hit_ok = (sh_adc[0] >= sh_wire_thr) && (sh_adc[4] >= sh_grid_thr) &&
                                (sh_adc[1] < sh_wire_thr) && (sh_adc[5] < sh_grid_thr);
                    fired = 1'b1;
                end
                sh_phase = PH_HUNT;
            end
            default: begin
                if (tag == sh_header_ident && w[WCNT_W-1:0] == sh_word_count) begin
                    sh_module = w[23:16];
                    sh_slot   = '0;
                    sh_phase  = PH_DATA;
                end else begin
                    sh_phase = PH_HUNT;
                end
            end
        endcase
        if (eob) begin
            sh_phase  = PH_HUNT;
            sh_slot   = '0;
            sh_module = '0;
        end
        return fired;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
        mismatches++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic eob);
        t_hit_event ev;
        int         gap;
        i_in_valid      <= 1'b1;
        i_word          <= w;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (step_parser(w, eob, ev)) begin
            hit_events_due.push_back(ev);
        end
        gap = throttle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (hit_events_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_write(idx, data);
    endtask

    task automatic apply_config(input logic [31:0] mask, input logic [31:0] hdr,
                                input logic [31:0] dat, input logic [31:0] ftr,
                                input logic [31:0] wcnt, input logic [31:0] wire_thr,
                                input logic [31:0] grid_thr);
        wait_drained();
        write_reg(CFG_ID_MASK, mask);
        write_reg(CFG_HEADER_IDENT, hdr);
        write_reg(CFG_DATA_IDENT, dat);
        write_reg(CFG_FOOTER_IDENT, ftr);
        write_reg(CFG_WORD_COUNT, wcnt);
        write_reg(CFG_WIRE_THR, wire_thr);
        write_reg(CFG_GRID_THR, grid_thr);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_adc pick_adc(input t_adc thr);
        case ($urandom_range(0, 4))
            0, 1: return t_adc'($urandom_range(0, 16383));
            2: return thr;
            3: return (thr == '0) ? thr : thr - t_adc'(1);
            default: return (thr == '1) ? thr : thr + t_adc'(1);
        endcase
    endfunction

    function automatic logic [31:0] frame_word(input int pos);
        logic [31:0] w;
        t_adc        thr;
        w = $urandom;
        if (pos == 0) begin
            w[WCNT_W-1:0] = sh_word_count;
            return (w & ~sh_id_mask) | sh_header_ident;
        end else if (pos == FRAME_WORDS - 1) begin
            return (w & ~sh_id_mask) | sh_footer_ident;
        end
        thr = (pos == 1 || pos == 2) ? sh_wire_thr : sh_grid_thr;
        if (pos >= 1 && pos <= 2 || pos >= 5 && pos <= 6) begin
            w[ADC_W-1:0] = pick_adc(thr);
        end
        return (w & ~sh_id_mask) | sh_data_ident;
    endfunction

    // Sends one frame; at break_at the word is corrupted or carries end of buffer
    // and the frame stops there.
    task automatic send_frame(input int break_at, output int sent);
        logic [31:0] w;
        logic        eob;
        sent = 0;
        for (int pos = 0; pos < FRAME_WORDS; pos++) begin
            w   = frame_word(pos);
            eob = 1'b0;
            if (pos == break_at) begin
                case ($urandom_range(0, 2))
                    0: w = $urandom;
                    1: eob = 1'b1;
                    default: w = w ^ (32'h1 << $urandom_range(0, 31));
                endcase
            end else if (pos == FRAME_WORDS - 1 && $urandom_range(0, 4) == 0) begin
                eob = 1'b1;
            end
            send_word(w, eob);
            sent++;
            if (pos == break_at) break;
        end
    endtask

    task automatic run_traffic(input int target);
        int counted;
        int sent;
        int r;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 5) == 0) begin
                throttle = ~throttle;
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_frame(-1, sent);
                counted += sent;
            end else if (r < 9) begin
                send_frame($urandom_range(0, FRAME_WORDS - 1), sent);
                counted += sent;
            end else begin
                send_word($urandom, $urandom_range(0, 7) == 0);
            end
        end
        throttle = 1'b1;
    endtask

    task automatic test_header_checks();
        send_word(32'h0100_0008, 1'b0);
        send_word(32'h00ab_0009, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0012_0008, 1'b1);
        send_word(32'h0000_0000, 1'b0);
    endtask

    task automatic test_data_abort();
        send_word(32'h0034_0008, 1'b0);
        send_word(32'h0000_1234, 1'b0);
        send_word(32'h0000_2345, 1'b0);
        send_word(32'h0000_3456, 1'b0);
        send_word(32'h7f00_0fff, 1'b0);
    endtask

    task automatic test_footer_checks();
        send_word(32'h00ff_0008, 1'b0);
        for (int i = 0; i < NUM_ADC; i++) begin
            send_word(i[0] ? 32'h0000_0000 : 32'h00ff_ffff, 1'b0);
        end
        send_word(32'h00ff_ffff, 1'b1);
        send_word(32'h0000_0008, 1'b0);
        for (int i = 0; i < NUM_ADC; i++) begin
            send_word(32'h0000_0000, 1'b0);
        end
        send_word(32'hff3f_ffff, 1'b0);
    endtask

    task automatic test_two_bit_types();
        apply_config(32'hc000_0000, 32'h4000_0000, 32'h0000_0000, 32'hc000_0000,
                     $urandom_range(0, 4095), $urandom_range(0, 16383),
                     $urandom_range(0, 16383));
        run_traffic(330);
    endtask

    task automatic test_register_extremes();
        apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        run_traffic(150);
    endtask

    task automatic test_exact_match();
        logic [WCNT_W-1:0] wcnt;
        logic [31:0]       hdr;
        wcnt = $urandom_range(0, 4095);
        hdr  = $urandom;
        hdr[WCNT_W-1:0] = wcnt;
        apply_config(32'hffff_ffff, hdr, $urandom, $urandom, {20'hfffff, wcnt},
                     32'hffff_c000, 32'hffff_c000);
        run_traffic(130);
    endtask

    task automatic test_byte_types();
        apply_config(32'hff00_0000, 32'h5a00_0000, 32'h3c00_0000, 32'he700_0000,
                     $urandom_range(0, 4095), $urandom_range(0, 16383),
                     $urandom_range(0, 16383));
        run_traffic(330);
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (throttle && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            rx_hold <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_hit_event want;
        t_adc       got_adc [NUM_ADC];
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_adc = '{o_adc0, o_adc1, o_adc2, o_adc3, o_adc4, o_adc5, o_adc6, o_adc7};
            if (hit_events_due.size() == 0) begin
                report_mismatch("unexpected event", 32'(o_timestamp), '0);
            end else begin
                want = hit_events_due.pop_front();
                if (o_module_res !== want.module_no) begin
                    report_mismatch("module", 32'(o_module_res), 32'(want.module_no));
                end
                for (int i = 0; i < NUM_ADC; i++) begin
                    if (got_adc[i] !== want.adc[i]) begin
                        report_mismatch($sformatf("adc%0d", i), 32'(got_adc[i]),
                                        32'(want.adc[i]));
                    end
                end
                if (o_timestamp !== want.stamp) begin
                    report_mismatch("timestamp", 32'(o_timestamp), 32'(want.stamp));
                end
                if (o_valid_res !== want.hit_ok) begin
                    report_mismatch("valid flag", 32'(o_valid_res), 32'(want.hit_ok));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_checks();
        test_data_abort();
        test_footer_checks();
        test_two_bit_types();
        test_register_extremes();
        test_exact_match();
        test_byte_types();
        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
